[rtl/core/ntk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntk_pkg
// Shared types and constants of the nibble trie key table.
// ----------------------------------------------------------------------------
package ntk_pkg;

  localparam int KeyLevelsDef  = 5;
  localparam int NodePoolDef   = 1024;
  localparam int RecordPoolDef = 256;
  localparam int Radix         = 16;
  localparam int NibW          = 4;
  localparam int KeyW          = 20;
  localparam int ValW          = 32;
  localparam int ReqW          = 2;
  localparam int StW           = 2;
  localparam int CntW          = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_DONE     = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOSTORE  = 2'd2,
    ST_NOTFOUND = 2'd3
  } st_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LINK_RD,
    OP_LINK_STEP,
    OP_ALLOC_RD,
    OP_ALLOC_WR,
    OP_SWEEP,
    OP_LEAF_RD,
    OP_REC_RD,
    OP_REC_WR,
    OP_VAL_RD,
    OP_REC_FREE,
    OP_PR_RD,
    OP_PR_UNLINK,
    OP_PR_DEC,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e  op;
    st_e  res_status;
    logic res_found;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic link_null;
    logic last_level;
    logic at_leaf;
    logic node_dry;
    logic rec_dry;
    logic leaf_null;
    logic fresh;
    logic sweep_last;
    logic val_zero;
    logic node_root;
    logic cnt_zero;
  } sts_t;

endpackage

[rtl/core/ntk_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntk_req_if
// Request channel: operation, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface ntk_req_if;
  logic                      valid;
  logic                      ready;
  logic [ntk_pkg::ReqW-1:0]  req_type;
  logic [ntk_pkg::KeyW-1:0]  key;
  logic [ntk_pkg::ValW-1:0]  value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

[rtl/core/ntk_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntk_rsp_if
// Response channel: status and found value with valid/ready.
// ----------------------------------------------------------------------------
interface ntk_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [ntk_pkg::StW-1:0]  status;
  logic [ntk_pkg::ValW-1:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink (input valid, status, found_value, output ready);
endinterface

[rtl/core/ntk_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntk_dp
// Trie datapath: link, count, parent, leaf, value and free list memories.
// ----------------------------------------------------------------------------
module ntk_dp #(
  parameter int KEY_LEVELS  = ntk_pkg::KeyLevelsDef,
  parameter int NODE_POOL   = ntk_pkg::NodePoolDef,
  parameter int RECORD_POOL = ntk_pkg::RecordPoolDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ntk_pkg::cmd_t            cmd_i,
  output ntk_pkg::sts_t            sts_o,
  input  logic [ntk_pkg::ReqW-1:0] req_type_i,
  input  logic [ntk_pkg::KeyW-1:0] key_i,
  input  logic [ntk_pkg::ValW-1:0] value_i,
  output logic [ntk_pkg::StW-1:0]  status_o,
  output logic [ntk_pkg::ValW-1:0] found_value_o
);

  localparam int NibW = ntk_pkg::NibW;
  localparam int NW   = $clog2(NODE_POOL);
  localparam int LA   = NW + NibW;
  localparam int NCW  = $clog2(NODE_POOL + 1);
  localparam int RW   = (RECORD_POOL > 1) ? $clog2(RECORD_POOL) : 1;
  localparam int RCW  = $clog2(RECORD_POOL + 1);
  localparam int LVW  = $clog2(KEY_LEVELS + 1);
  localparam int CntW = ntk_pkg::CntW;

  // memories
  logic [NW-1:0]           link_mem [NODE_POOL*ntk_pkg::Radix];
  logic [CntW-1:0]         cnt_mem  [NODE_POOL];
  logic [LA-1:0]           par_mem  [NODE_POOL];
  logic [RCW-1:0]          leaf_mem [NODE_POOL];
  logic [ntk_pkg::ValW-1:0] val_mem [RECORD_POOL];
  logic [NW-1:0]           nfl_mem  [NODE_POOL];
  logic [RW-1:0]           rfl_mem  [RECORD_POOL];

  logic [NW-1:0]            link_rd_q;
  logic [CntW-1:0]          cnt_rd_q;
  logic [LA-1:0]            par_rd_q;
  logic [RCW-1:0]           leaf_rd_q;
  logic [ntk_pkg::ValW-1:0] val_rd_q;
  logic [NW-1:0]            nfl_rd_q;
  logic [RW-1:0]            rfl_rd_q;

  // working registers
  ntk_pkg::req_e            req_q;
  logic [ntk_pkg::KeyW-1:0] key_q;
  logic [ntk_pkg::ValW-1:0] val_q;
  logic [NW-1:0]            node_q;
  logic [NibW-1:0]          slot_q;
  logic [LVW-1:0]           lvl_q;
  logic                     rd_root_q;
  logic [NW-1:0]            npop_q;
  logic                     fresh_q;
  logic [RW-1:0]            rpop_q;
  logic                     rfresh_q;
  logic [NibW-1:0]          sweep_q;
  logic [ntk_pkg::StW-1:0]  status_q;
  logic [ntk_pkg::ValW-1:0] found_q;

  // control state
  logic [NCW-1:0]           ncnt_q, nlow_q;
  logic [RCW-1:0]           rcnt_q, rlow_q;
  logic [ntk_pkg::Radix-1:0] root_vld_q;

  ntk_pkg::op_e  op;
  logic [NW-1:0] link_c;
  logic [NW-1:0] alloc_n;
  logic [RW-1:0] rec_r;
  logic [NW-1:0] par_node;
  logic [NCW-1:0] ncnt_dec;
  logic [RCW-1:0] rcnt_dec;

  logic            link_we;
  logic [LA-1:0]   link_wa;
  logic [NW-1:0]   link_wd;
  logic            cnt_we;
  logic [NW-1:0]   cnt_wa;
  logic [CntW-1:0] cnt_wd;
  logic            leaf_we;
  logic [RCW-1:0]  leaf_wd;
  logic            cnt_re;
  logic [NW-1:0]   cnt_ra;

  assign op       = cmd_i.op;
  assign par_node = par_rd_q[LA-1:NibW];
  assign ncnt_dec = ncnt_q - NCW'(1);
  assign rcnt_dec = rcnt_q - RCW'(1);
  assign link_c   = (rd_root_q && !root_vld_q[slot_q]) ? '0 : link_rd_q;
  // a slot below the low-water mark was never pushed, so its entry is computed instead of read
  assign alloc_n  = fresh_q ? (NW'(NODE_POOL - 1) - npop_q) : nfl_rd_q;
  assign rec_r    = rfresh_q ? (RW'(RECORD_POOL - 1) - rpop_q) : rfl_rd_q;

  always_comb begin
    link_we = 1'b0;
    link_wa = {node_q, slot_q};
    link_wd = '0;
    cnt_we  = 1'b0;
    cnt_wa  = node_q;
    cnt_wd  = '0;
    leaf_we = 1'b0;
    leaf_wd = '0;
    unique case (op)
      ntk_pkg::OP_ALLOC_WR: begin
        link_we = 1'b1;
        link_wd = alloc_n;
        cnt_we  = 1'b1;
        cnt_wd  = cnt_rd_q + CntW'(1);
      end
      ntk_pkg::OP_SWEEP: begin
        link_we = 1'b1;
        link_wa = {node_q, sweep_q};
        cnt_we  = 1'b1;
        leaf_we = 1'b1;
      end
      ntk_pkg::OP_PR_UNLINK: begin
        link_we = 1'b1;
        link_wa = par_rd_q;
      end
      ntk_pkg::OP_PR_DEC: begin
        cnt_we = (cnt_rd_q != '0);
        cnt_wd = cnt_rd_q - CntW'(1);
      end
      ntk_pkg::OP_REC_WR: begin
        leaf_we = 1'b1;
        leaf_wd = RCW'(rec_r) + RCW'(1);
      end
      ntk_pkg::OP_REC_FREE: begin
        leaf_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cnt_re = (op == ntk_pkg::OP_ALLOC_RD) || (op == ntk_pkg::OP_PR_RD) ||
                  (op == ntk_pkg::OP_PR_UNLINK);
  assign cnt_ra = (op == ntk_pkg::OP_PR_UNLINK) ? par_node : node_q;

  // memory ports
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (op == ntk_pkg::OP_LINK_RD) link_rd_q <= link_mem[{node_q, key_q[NibW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (op == ntk_pkg::OP_ALLOC_WR) par_mem[alloc_n] <= {node_q, slot_q};
    if (op == ntk_pkg::OP_PR_RD) par_rd_q <= par_mem[node_q];
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) leaf_mem[node_q] <= leaf_wd;
    if (op == ntk_pkg::OP_LEAF_RD) leaf_rd_q <= leaf_mem[node_q];
  end

  always_ff @(posedge clk_i) begin
    if (op == ntk_pkg::OP_REC_WR) val_mem[rec_r] <= val_q;
    if (op == ntk_pkg::OP_VAL_RD) val_rd_q <= val_mem[RW'(leaf_rd_q - RCW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (op == ntk_pkg::OP_PR_UNLINK) nfl_mem[ncnt_q[NW-1:0]] <= node_q;
    if (op == ntk_pkg::OP_ALLOC_RD) nfl_rd_q <= nfl_mem[ncnt_dec[NW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (op == ntk_pkg::OP_REC_FREE) rfl_mem[rcnt_q[RW-1:0]] <= RW'(leaf_rd_q - RCW'(1));
    if (op == ntk_pkg::OP_REC_RD) rfl_rd_q <= rfl_mem[rcnt_dec[RW-1:0]];
  end

  // pool counters and root link valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q     <= NCW'(NODE_POOL - 1);
      nlow_q     <= NCW'(NODE_POOL - 1);
      rcnt_q     <= RCW'(RECORD_POOL);
      rlow_q     <= RCW'(RECORD_POOL);
      root_vld_q <= '0;
    end else begin
      unique case (op)
        ntk_pkg::OP_ALLOC_RD: begin
          ncnt_q <= ncnt_dec;
          if (ncnt_dec < nlow_q) nlow_q <= ncnt_dec;
        end
        ntk_pkg::OP_ALLOC_WR: begin
          if (node_q == '0) root_vld_q[slot_q] <= 1'b1;
        end
        ntk_pkg::OP_PR_UNLINK: begin
          ncnt_q <= ncnt_q + NCW'(1);
          if (par_node == '0) root_vld_q[par_rd_q[NibW-1:0]] <= 1'b1;
        end
        ntk_pkg::OP_REC_RD: begin
          rcnt_q <= rcnt_dec;
          if (rcnt_dec < rlow_q) rlow_q <= rcnt_dec;
        end
        ntk_pkg::OP_REC_FREE: begin
          rcnt_q <= rcnt_q + RCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    unique case (op)
      ntk_pkg::OP_LOAD: begin
        req_q  <= ntk_pkg::req_e'(req_type_i);
        key_q  <= key_i;
        val_q  <= value_i;
        node_q <= '0;
        lvl_q  <= '0;
      end
      ntk_pkg::OP_LINK_RD: begin
        slot_q    <= key_q[NibW-1:0];
        rd_root_q <= (node_q == '0);
      end
      ntk_pkg::OP_LINK_STEP: begin
        node_q <= link_c;
        key_q  <= key_q >> NibW;
        lvl_q  <= lvl_q + LVW'(1);
      end
      ntk_pkg::OP_ALLOC_RD: begin
        npop_q  <= ncnt_dec[NW-1:0];
        fresh_q <= (ncnt_dec < nlow_q);
      end
      ntk_pkg::OP_ALLOC_WR: begin
        node_q  <= alloc_n;
        key_q   <= key_q >> NibW;
        lvl_q   <= lvl_q + LVW'(1);
        sweep_q <= '0;
      end
      ntk_pkg::OP_SWEEP: begin
        sweep_q <= sweep_q + NibW'(1);
      end
      ntk_pkg::OP_REC_RD: begin
        rpop_q   <= rcnt_dec[RW-1:0];
        rfresh_q <= (rcnt_dec < rlow_q);
      end
      ntk_pkg::OP_PR_UNLINK: begin
        node_q <= par_node;
      end
      ntk_pkg::OP_RESULT: begin
        status_q <= cmd_i.res_status;
        found_q  <= cmd_i.res_found ? val_rd_q : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o            = '0;
    sts_o.req        = req_q;
    sts_o.link_null  = (link_c == '0);
    sts_o.last_level = (lvl_q == LVW'(KEY_LEVELS - 1));
    sts_o.at_leaf    = (lvl_q == LVW'(KEY_LEVELS));
    sts_o.node_dry   = (ncnt_q == '0);
    sts_o.rec_dry    = (rcnt_q == '0);
    sts_o.leaf_null  = (leaf_rd_q == '0);
    sts_o.fresh      = fresh_q;
    sts_o.sweep_last = (sweep_q == NibW'(ntk_pkg::Radix - 1));
    sts_o.val_zero   = (val_rd_q == '0);
    sts_o.node_root  = (node_q == '0);
    sts_o.cnt_zero   = (cnt_rd_q == '0);
  end

  assign status_o      = status_q;
  assign found_value_o = found_q;

endmodule

[rtl/core/ntk_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntk_ctrl
// Sequencer for insert, find and remove walks over the trie datapath.
// ----------------------------------------------------------------------------
module ntk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ntk_pkg::sts_t sts_i,
  output ntk_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LINK_RD,
    S_LINK_CHK,
    S_ALLOC_WR,
    S_SWEEP,
    S_LEAF_RD,
    S_LEAF_CHK,
    S_REC_WR,
    S_VAL_CHK,
    S_PR_RD,
    S_PR_CHK,
    S_PR_DEC,
    S_RESP
  } state_e;

  state_e       state_q, state_d;
  ntk_pkg::st_e res_q, res_d;
  logic         fnd_q, fnd_d;
  logic         out_valid_q;
  logic         out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    res_d             = res_q;
    fnd_d             = fnd_q;
    cmd_o.op          = ntk_pkg::OP_NOP;
    cmd_o.res_status  = res_q;
    cmd_o.res_found   = fnd_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ntk_pkg::OP_LOAD;
          fnd_d    = 1'b0;
          state_d  = S_LINK_RD;
        end
      end
      S_LINK_RD: begin
        if (sts_i.req == ntk_pkg::REQ_UNUSED) begin
          res_d   = ntk_pkg::ST_NOTFOUND;
          state_d = S_RESP;
        end else begin
          cmd_o.op = ntk_pkg::OP_LINK_RD;
          state_d  = S_LINK_CHK;
        end
      end
      S_LINK_CHK: begin
        if (!sts_i.link_null) begin
          cmd_o.op = ntk_pkg::OP_LINK_STEP;
          state_d  = sts_i.last_level ? S_LEAF_RD : S_LINK_RD;
        end else if (sts_i.req != ntk_pkg::REQ_INSERT) begin
          res_d   = ntk_pkg::ST_NOTFOUND;
          state_d = S_RESP;
        end else if (sts_i.node_dry) begin
          res_d   = ntk_pkg::ST_NOSTORE;
          state_d = S_RESP;
        end else begin
          cmd_o.op = ntk_pkg::OP_ALLOC_RD;
          state_d  = S_ALLOC_WR;
        end
      end
      S_ALLOC_WR: begin
        cmd_o.op = ntk_pkg::OP_ALLOC_WR;
        // a node taken for the first time gets its links cleared
        if (sts_i.fresh) state_d = S_SWEEP;
        else state_d = sts_i.last_level ? S_LEAF_RD : S_LINK_RD;
      end
      S_SWEEP: begin
        cmd_o.op = ntk_pkg::OP_SWEEP;
        if (sts_i.sweep_last) state_d = sts_i.at_leaf ? S_LEAF_RD : S_LINK_RD;
      end
      S_LEAF_RD: begin
        cmd_o.op = ntk_pkg::OP_LEAF_RD;
        state_d  = S_LEAF_CHK;
      end
      S_LEAF_CHK: begin
        priority if (sts_i.req == ntk_pkg::REQ_INSERT) begin
          if (!sts_i.leaf_null) begin
            res_d   = ntk_pkg::ST_PRESENT;
            state_d = S_RESP;
          end else if (sts_i.rec_dry) begin
            res_d   = ntk_pkg::ST_NOSTORE;
            state_d = S_RESP;
          end else begin
            cmd_o.op = ntk_pkg::OP_REC_RD;
            state_d  = S_REC_WR;
          end
        end else if (sts_i.leaf_null) begin
          res_d   = ntk_pkg::ST_NOTFOUND;
          state_d = S_RESP;
        end else if (sts_i.req == ntk_pkg::REQ_FIND) begin
          cmd_o.op = ntk_pkg::OP_VAL_RD;
          state_d  = S_VAL_CHK;
        end else begin
          cmd_o.op = ntk_pkg::OP_REC_FREE;
          state_d  = S_PR_RD;
        end
      end
      S_REC_WR: begin
        cmd_o.op = ntk_pkg::OP_REC_WR;
        res_d    = ntk_pkg::ST_DONE;
        state_d  = S_RESP;
      end
      S_VAL_CHK: begin
        // a stored zero reads as absent
        res_d   = sts_i.val_zero ? ntk_pkg::ST_NOTFOUND : ntk_pkg::ST_DONE;
        fnd_d   = !sts_i.val_zero;
        state_d = S_RESP;
      end
      S_PR_RD: begin
        if (sts_i.node_root) begin
          res_d   = ntk_pkg::ST_DONE;
          state_d = S_RESP;
        end else begin
          cmd_o.op = ntk_pkg::OP_PR_RD;
          state_d  = S_PR_CHK;
        end
      end
      S_PR_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.op = ntk_pkg::OP_PR_UNLINK;
          state_d  = S_PR_DEC;
        end else begin
          res_d   = ntk_pkg::ST_DONE;
          state_d = S_RESP;
        end
      end
      S_PR_DEC: begin
        cmd_o.op = ntk_pkg::OP_PR_DEC;
        state_d  = S_PR_RD;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.op = ntk_pkg::OP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_q       <= ntk_pkg::ST_DONE;
      fnd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      fnd_q   <= fnd_d;
      if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

[rtl/core/nibble_trie_key_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_trie_key_table_top
// Map from a 20-bit key to a 32-bit value kept in a radix-16 trie.
// ----------------------------------------------------------------------------
// Usage: the request channel req_i takes one beat per operation (insert,
// find, remove) with its key and value; the response channel rsp_o returns
// exactly one beat per request, status plus found value, in request order.
// The block works on one request at a time. Each trie level takes a
// registered link memory read, then a check. Insert adds an allocation
// step per created node, plus a sweep that clears the node's link row the
// first time a node is ever taken from the pool. Remove adds a parent read,
// an unlink and a count decrement per pruned level.
// After reset the trie is empty and both pools are full; no clearing pass
// is needed, so a request is taken in the first cycle after reset.
// A result waits in an output register while the receiver stalls; the next
// request is accepted meanwhile and runs until its own result is ready.
// ----------------------------------------------------------------------------
module nibble_trie_key_table_top #(
  parameter int KEY_LEVELS  = ntk_pkg::KeyLevelsDef,
  parameter int NODE_POOL   = ntk_pkg::NodePoolDef,
  parameter int RECORD_POOL = ntk_pkg::RecordPoolDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntk_req_if.sink    req_i,
  ntk_rsp_if.source  rsp_o
);

  ntk_pkg::cmd_t cmd;
  ntk_pkg::sts_t sts;

  ntk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ntk_dp #(
    .KEY_LEVELS  (KEY_LEVELS),
    .NODE_POOL   (NODE_POOL),
    .RECORD_POOL (RECORD_POOL)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .key_i         (req_i.key),
    .value_i       (req_i.value),
    .status_o      (rsp_o.status),
    .found_value_o (rsp_o.found_value)
  );

endmodule
